// ===== rtl/pgs_pkg.sv =====
// Shared types and constants for the pairwise gravity step block.
`timescale 1ns / 1ps

package pgs_pkg;

  localparam int MAX_BODIES_DEF = 64;
  localparam int MAX_OUT        = 64;
  localparam logic [15:0] GRAV_RESET = 16'd10;

  // Width of the pair distance r in Q16 (at most about 2^32.5).
  localparam int RW = 34;

  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;

  localparam logic [46:0] FORCE_CAP = 47'h4000_0000_0000;
  localparam logic [16:0] UNIT_ONE  = 17'h1_0000;

  typedef enum logic [1:0] {
    ST_ADDED  = 2'd0,
    ST_REJECT = 2'd1,
    ST_BODY   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic {
    OP_SQRT = 1'b0,
    OP_DIV  = 1'b1
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } arith_stat_t;

  typedef struct packed {
    logic [15:0]        mass;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
  } body_t;

endpackage

// ===== rtl/pgs_arith.sv =====
// Shared iterative unit: 64-bit integer square root and 64 by 34 bit restoring divide.
`timescale 1ns / 1ps

module pgs_arith (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pgs_pkg::arith_req_t       req,
  input  logic [63:0]               opa,
  input  logic [pgs_pkg::RW-1:0]    opb,
  output pgs_pkg::arith_stat_t      stat,
  output logic [63:0]               result
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  pgs_pkg::arith_op_t    op_r, op_nxt;
  logic [5:0]            cnt_r, cnt_nxt;
  logic [63:0]           x_r, x_nxt;
  logic [63:0]           y_r, y_nxt;
  logic [63:0]           bit_r, bit_nxt;
  logic [pgs_pkg::RW-1:0] b_r, b_nxt;

  logic [pgs_pkg::RW:0]  dtrial;
  logic                  dfit;
  logic [63:0]           strial;
  logic                  sfit;

  always_comb begin
    dtrial   = {y_r[pgs_pkg::RW-1:0], x_r[63]};
    dfit     = dtrial >= {1'b0, b_r};
    strial   = y_r + bit_r;
    sfit     = x_r >= strial;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    bit_nxt  = bit_r;
    b_nxt    = b_r;
    if (busy_r) begin
      if (op_r == pgs_pkg::OP_DIV) begin
        // x shifts the dividend out and the quotient in; y keeps the remainder.
        x_nxt = {x_r[62:0], dfit};
        y_nxt = dfit ? 64'(dtrial - {1'b0, b_r}) : 64'(dtrial);
      end else begin
        if (sfit) begin
          x_nxt = x_r - strial;
          y_nxt = (y_r >> 1) + bit_r;
        end else begin
          y_nxt = y_r >> 1;
        end
        bit_nxt = bit_r >> 2;
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      b_nxt    = opb;
      x_nxt    = opa;
      y_nxt    = '0;
      bit_nxt  = 64'h4000_0000_0000_0000;
      cnt_nxt  = (req.op == pgs_pkg::OP_DIV) ? 6'(pgs_pkg::DIV_STEPS - 1)
                                              : 6'(pgs_pkg::SQRT_STEPS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    bit_r <= bit_nxt;
    b_r   <= b_nxt;
  end

  assign stat   = '{busy: busy_r, done: done_r};
  assign result = (op_r == pgs_pkg::OP_DIV) ? x_r : y_r;

endmodule

// ===== rtl/pairwise_gravity_step.sv =====
// Top level: body store, pair sequencer and result channel of the gravity step block.
`timescale 1ns / 1ps
// An add, a rejected add and a step with no bodies give one result in the cycle after acceptance.
// A step takes each pair in turn through a 32-step square root and six 64-step divides in the
// shared unit; a coincident pair skips the divides, and a saturated force skips one of them,
// and the result side can stall the step.
// One request is in work at a time; the input is stalled until the last result is loaded and taken.
// Reset (synchronous, active low) empties the body count and sets the gravity scale to 10.

module pairwise_gravity_step #(
  parameter int MAX_BODIES = pgs_pkg::MAX_BODIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [15:0]        in_mass,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [5:0]         out_body_index,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic               out_last
);

  localparam int IW   = $clog2(MAX_BODIES);
  localparam int CW   = $clog2(MAX_BODIES + 1);
  localparam int NOUT = (MAX_BODIES < pgs_pkg::MAX_OUT) ? MAX_BODIES : pgs_pkg::MAX_OUT;
  localparam int RW   = pgs_pkg::RW;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_I, S_RD_J, S_LAT_J, S_DIFF, S_SQX, S_SQY, S_SQRT, S_SQRT_WAIT,
    S_KI, S_KJ, S_KJ_ST, S_DIV, S_DIV_WAIT, S_AHI, S_ALO, S_APPLY, S_POS,
    S_WR_I, S_WR_J, S_EM_RD, S_EM_OUT
  } state_t;

  typedef enum logic [2:0] {D_UX, D_UY, D_TI, D_FI, D_TJ, D_FJ} dsel_t;

  function automatic logic [31:0] sat32(input logic [48:0] s);
    logic [31:0] r;
    if (s[48:31] != {18{s[48]}}) begin
      r = s[48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  state_t             state_r, state_nxt;
  dsel_t              dsel_r, dsel_nxt;
  logic [15:0]        grav_r, grav_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [IW-1:0]      i_r, i_nxt, j_r, j_nxt, em_r, em_nxt;
  pgs_pkg::body_t     bi_r, bi_nxt, bj_r, bj_nxt;
  logic               dx_neg_r, dx_neg_nxt, dy_neg_r, dy_neg_nxt;
  logic [32:0]        ax_r, ax_nxt, ay_r, ay_nxt;
  logic               sh_r, sh_nxt;
  logic [63:0]        sq_r, sq_nxt, prod_r, prod_nxt;
  logic [RW-1:0]      r_r, r_nxt;
  logic [16:0]        ux_r, ux_nxt, uy_r, uy_nxt;
  logic [31:0]        ki_r, ki_nxt, kj_r, kj_nxt;
  logic [39:0]        t_r, t_nxt;
  logic [46:0]        fi_r, fi_nxt, fj_r, fj_nxt, acc_r, acc_nxt;
  logic [1:0]         astep_r, astep_nxt;

  logic               out_valid_r, out_valid_nxt;
  pgs_pkg::status_t   out_status_r, out_status_nxt;
  logic [5:0]         out_idx_r, out_idx_nxt;
  logic [31:0]        out_px_r, out_px_nxt, out_py_r, out_py_nxt;
  logic [31:0]        out_vx_r, out_vx_nxt, out_vy_r, out_vy_nxt;
  logic               out_last_r, out_last_nxt;

  pgs_pkg::body_t     mem [MAX_BODIES];
  pgs_pkg::body_t     rd_data_r, wr_data;
  logic               rd_en, wr_en;
  logic [IW-1:0]      rd_addr, wr_addr;

  pgs_pkg::arith_req_t  a_req;
  pgs_pkg::arith_stat_t a_stat;
  logic [63:0]          a_opa, a_res;

  logic [31:0]        mul_a, mul_b;
  logic               out_free, in_acc, em_last;
  logic [32:0]        dx, dy, ax, ay;
  logic [46:0]        f_sel, accel;
  logic [16:0]        u_sel;
  logic               neg_sel;
  logic [31:0]        v_sel;
  logic [31:0]        v_new;

  pgs_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (a_req),
    .opa    (a_opa),
    .opb    (r_r),
    .stat   (a_stat),
    .result (a_res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign em_last  = ((CW'(em_r) + CW'(1)) == count_r) || ((CW'(em_r) + CW'(1)) == CW'(NOUT));

  always_comb begin
    dx = {bj_r.pos_x[31], bj_r.pos_x} - {bi_r.pos_x[31], bi_r.pos_x};
    dy = {bj_r.pos_y[31], bj_r.pos_y} - {bi_r.pos_y[31], bi_r.pos_y};
    ax = dx[32] ? -dx : dx;
    ay = dy[32] ? -dy : dy;
    f_sel = astep_r[1] ? fj_r : fi_r;
    u_sel = astep_r[0] ? uy_r : ux_r;
    case (astep_r)
      2'd0:    begin neg_sel = dx_neg_r;  v_sel = bi_r.vel_x; end
      2'd1:    begin neg_sel = dy_neg_r;  v_sel = bi_r.vel_y; end
      2'd2:    begin neg_sel = !dx_neg_r; v_sel = bj_r.vel_x; end
      default: begin neg_sel = !dy_neg_r; v_sel = bj_r.vel_y; end
    endcase
    accel = acc_r + 47'(prod_r >> 16);
    v_new = sat32({{17{v_sel[31]}}, v_sel} +
                  (neg_sel ? -{2'b00, accel} : {2'b00, accel}));
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SQX:   begin mul_a = 32'(ax_r >> sh_r); mul_b = 32'(ax_r >> sh_r); end
      S_SQY:   begin mul_a = 32'(ay_r >> sh_r); mul_b = 32'(ay_r >> sh_r); end
      S_KI:    begin mul_a = 32'(grav_r); mul_b = 32'(bj_r.mass); end
      S_KJ:    begin mul_a = 32'(grav_r); mul_b = 32'(bi_r.mass); end
      S_AHI:   begin mul_a = 32'(f_sel[46:16]); mul_b = 32'(u_sel); end
      S_ALO:   begin mul_a = 32'(f_sel[15:0]);  mul_b = 32'(u_sel); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  always_comb begin
    a_req = '{start: 1'b0, op: pgs_pkg::OP_SQRT};
    a_opa = sq_r + prod_r;
    if (state_r == S_SQRT) begin
      a_req = '{start: !a_stat.busy, op: pgs_pkg::OP_SQRT};
    end else if (state_r == S_DIV) begin
      a_req = '{start: !a_stat.busy, op: pgs_pkg::OP_DIV};
      case (dsel_r)
        D_UX:    a_opa = 64'({ax_r, 16'h0000});
        D_UY:    a_opa = 64'({ay_r, 16'h0000});
        D_TI:    a_opa = 64'({ki_r, 24'h00_0000});
        D_TJ:    a_opa = 64'({kj_r, 24'h00_0000});
        default: a_opa = {t_r, 24'h00_0000};
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    dsel_nxt  = dsel_r;
    grav_nxt  = cfg_wr_en ? cfg_wr_data : grav_r;
    count_nxt = count_r;
    i_nxt = i_r;  j_nxt = j_r;  em_nxt = em_r;
    bi_nxt = bi_r;  bj_nxt = bj_r;
    dx_neg_nxt = dx_neg_r;  dy_neg_nxt = dy_neg_r;
    ax_nxt = ax_r;  ay_nxt = ay_r;  sh_nxt = sh_r;
    sq_nxt = sq_r;  r_nxt = r_r;
    ux_nxt = ux_r;  uy_nxt = uy_r;
    ki_nxt = ki_r;  kj_nxt = kj_r;  t_nxt = t_r;
    fi_nxt = fi_r;  fj_nxt = fj_r;  acc_nxt = acc_r;
    astep_nxt = astep_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_px_nxt = out_px_r;  out_py_nxt = out_py_r;
    out_vx_nxt = out_vx_r;  out_vy_nxt = out_vy_r;
    out_last_nxt = out_last_r;
    rd_en   = 1'b0;
    rd_addr = i_r;
    wr_en   = 1'b0;
    wr_addr = i_r;
    wr_data = bi_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!in_mode) begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b1;
            if (count_r >= CW'(MAX_BODIES)) begin
              out_status_nxt = pgs_pkg::ST_REJECT;
              out_idx_nxt = '0;
              out_px_nxt = '0;  out_py_nxt = '0;  out_vx_nxt = '0;  out_vy_nxt = '0;
            end else begin
              wr_en   = 1'b1;
              wr_addr = IW'(count_r);
              wr_data = '{mass: in_mass, pos_x: in_pos_x, pos_y: in_pos_y,
                          vel_x: in_vel_x, vel_y: in_vel_y};
              count_nxt = count_r + CW'(1);
              out_status_nxt = pgs_pkg::ST_ADDED;
              out_idx_nxt = 6'(count_r);
              out_px_nxt = in_pos_x;  out_py_nxt = in_pos_y;
              out_vx_nxt = in_vel_x;  out_vy_nxt = in_vel_y;
            end
          end else if (count_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_last_nxt   = 1'b1;
            out_status_nxt = pgs_pkg::ST_EMPTY;
            out_idx_nxt = '0;
            out_px_nxt = '0;  out_py_nxt = '0;  out_vx_nxt = '0;  out_vy_nxt = '0;
          end else if (count_r == CW'(1)) begin
            em_nxt    = '0;
            state_nxt = S_EM_RD;
          end else begin
            i_nxt     = '0;
            j_nxt     = IW'(1);
            state_nxt = S_RD_I;
          end
        end
      end
      S_RD_I: begin
        rd_en     = 1'b1;
        rd_addr   = i_r;
        state_nxt = S_RD_J;
      end
      S_RD_J: begin
        bi_nxt    = rd_data_r;
        rd_en     = 1'b1;
        rd_addr   = j_r;
        state_nxt = S_LAT_J;
      end
      S_LAT_J: begin
        bj_nxt    = rd_data_r;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        dx_neg_nxt = dx[32];
        dy_neg_nxt = dy[32];
        ax_nxt     = ax;
        ay_nxt     = ay;
        // Halve both components when either reaches 2^31 so the squares fit 64 bits.
        sh_nxt     = ax[32] | ax[31] | ay[32] | ay[31];
        state_nxt  = S_SQX;
      end
      S_SQX: state_nxt = S_SQY;
      S_SQY: begin
        sq_nxt    = prod_r;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (!a_stat.busy) begin
          state_nxt = S_SQRT_WAIT;
        end
      end
      S_SQRT_WAIT: begin
        if (a_stat.done) begin
          r_nxt = RW'(a_res[32:0]) << sh_r;
          // Coincident bodies get no pull; only their positions advance.
          state_nxt = (a_res == '0) ? S_POS : S_KI;
        end
      end
      S_KI: state_nxt = S_KJ;
      S_KJ: begin
        ki_nxt    = prod_r[31:0];
        state_nxt = S_KJ_ST;
      end
      S_KJ_ST: begin
        kj_nxt    = prod_r[31:0];
        dsel_nxt  = D_UX;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (!a_stat.busy) begin
          state_nxt = S_DIV_WAIT;
        end
      end
      S_DIV_WAIT: begin
        if (a_stat.done) begin
          state_nxt = S_DIV;
          case (dsel_r)
            D_UX: begin
              ux_nxt   = (a_res > 64'(pgs_pkg::UNIT_ONE)) ? pgs_pkg::UNIT_ONE : a_res[16:0];
              dsel_nxt = D_UY;
            end
            D_UY: begin
              uy_nxt   = (a_res > 64'(pgs_pkg::UNIT_ONE)) ? pgs_pkg::UNIT_ONE : a_res[16:0];
              dsel_nxt = D_TI;
            end
            D_TI: begin
              if (a_res[63:40] != '0) begin
                fi_nxt   = pgs_pkg::FORCE_CAP;
                dsel_nxt = D_TJ;
              end else begin
                t_nxt    = a_res[39:0];
                dsel_nxt = D_FI;
              end
            end
            D_FI: begin
              fi_nxt   = (a_res > 64'(pgs_pkg::FORCE_CAP)) ? pgs_pkg::FORCE_CAP : a_res[46:0];
              dsel_nxt = D_TJ;
            end
            D_TJ: begin
              if (a_res[63:40] != '0) begin
                fj_nxt    = pgs_pkg::FORCE_CAP;
                astep_nxt = '0;
                state_nxt = S_AHI;
              end else begin
                t_nxt    = a_res[39:0];
                dsel_nxt = D_FJ;
              end
            end
            default: begin
              fj_nxt    = (a_res > 64'(pgs_pkg::FORCE_CAP)) ? pgs_pkg::FORCE_CAP : a_res[46:0];
              astep_nxt = '0;
              state_nxt = S_AHI;
            end
          endcase
        end
      end
      S_AHI: state_nxt = S_ALO;
      S_ALO: begin
        // f*u >> 16 is built as (f_hi * u) + ((f_lo * u) >> 16), exactly.
        acc_nxt   = prod_r[46:0];
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        case (astep_r)
          2'd0:    bi_nxt.vel_x = v_new;
          2'd1:    bi_nxt.vel_y = v_new;
          2'd2:    bj_nxt.vel_x = v_new;
          default: bj_nxt.vel_y = v_new;
        endcase
        astep_nxt = astep_r + 2'd1;
        state_nxt = (astep_r == 2'd3) ? S_POS : S_AHI;
      end
      S_POS: begin
        bi_nxt.pos_x = sat32({{17{bi_r.pos_x[31]}}, bi_r.pos_x} +
                             {{17{bi_r.vel_x[31]}}, bi_r.vel_x});
        bi_nxt.pos_y = sat32({{17{bi_r.pos_y[31]}}, bi_r.pos_y} +
                             {{17{bi_r.vel_y[31]}}, bi_r.vel_y});
        bj_nxt.pos_x = sat32({{17{bj_r.pos_x[31]}}, bj_r.pos_x} +
                             {{17{bj_r.vel_x[31]}}, bj_r.vel_x});
        bj_nxt.pos_y = sat32({{17{bj_r.pos_y[31]}}, bj_r.pos_y} +
                             {{17{bj_r.vel_y[31]}}, bj_r.vel_y});
        state_nxt = S_WR_I;
      end
      S_WR_I: begin
        wr_en     = 1'b1;
        wr_addr   = i_r;
        wr_data   = bi_r;
        state_nxt = S_WR_J;
      end
      S_WR_J: begin
        wr_en   = 1'b1;
        wr_addr = j_r;
        wr_data = bj_r;
        if ((CW'(j_r) + CW'(1)) < count_r) begin
          j_nxt     = j_r + IW'(1);
          state_nxt = S_RD_I;
        end else if ((CW'(i_r) + CW'(2)) < count_r) begin
          i_nxt     = i_r + IW'(1);
          j_nxt     = i_r + IW'(2);
          state_nxt = S_RD_I;
        end else begin
          em_nxt    = '0;
          state_nxt = S_EM_RD;
        end
      end
      S_EM_RD: begin
        rd_en     = 1'b1;
        rd_addr   = em_r;
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pgs_pkg::ST_BODY;
          out_idx_nxt    = 6'(em_r);
          out_px_nxt = rd_data_r.pos_x;  out_py_nxt = rd_data_r.pos_y;
          out_vx_nxt = rd_data_r.vel_x;  out_vy_nxt = rd_data_r.vel_y;
          out_last_nxt = em_last;
          if (em_last) begin
            state_nxt = S_IDLE;
          end else begin
            em_nxt    = em_r + IW'(1);
            state_nxt = S_EM_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      grav_r      <= pgs_pkg::GRAV_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      grav_r      <= grav_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    dsel_r   <= dsel_nxt;
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    em_r     <= em_nxt;
    bi_r     <= bi_nxt;
    bj_r     <= bj_nxt;
    dx_neg_r <= dx_neg_nxt;
    dy_neg_r <= dy_neg_nxt;
    ax_r     <= ax_nxt;
    ay_r     <= ay_nxt;
    sh_r     <= sh_nxt;
    sq_r     <= sq_nxt;
    prod_r   <= prod_nxt;
    r_r      <= r_nxt;
    ux_r     <= ux_nxt;
    uy_r     <= uy_nxt;
    ki_r     <= ki_nxt;
    kj_r     <= kj_nxt;
    t_r      <= t_nxt;
    fi_r     <= fi_nxt;
    fj_r     <= fj_nxt;
    acc_r    <= acc_nxt;
    astep_r  <= astep_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_px_r     <= out_px_nxt;
    out_py_r     <= out_py_nxt;
    out_vx_r     <= out_vx_nxt;
    out_vy_r     <= out_vy_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_body_index = out_idx_r;
  assign out_pos_x      = out_px_r;
  assign out_pos_y      = out_py_r;
  assign out_vel_x      = out_vx_r;
  assign out_vel_y      = out_vy_r;
  assign out_last       = out_last_r;

endmodule

// ===== rtl/pgs_checker.sv =====
// Port-level checks for the gravity step block, bound to its top level.
`timescale 1ns / 1ps

module pgs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_mode,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic [5:0]         out_body_index,
  input logic signed [31:0] out_pos_x,
  input logic signed [31:0] out_vel_y,
  input logic               out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x) && $stable(out_body_index))
    else $error("stalled result changed");

  a_add_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_mode |=> out_valid && out_last &&
    (out_status == pgs_pkg::ST_ADDED || out_status == pgs_pkg::ST_REJECT))
    else $error("add request did not give a single added or rejected result");

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == pgs_pkg::ST_REJECT || out_status == pgs_pkg::ST_EMPTY) |->
    out_last && out_pos_x == 0 && out_vel_y == 0 && out_body_index == 0)
    else $error("rejected or empty result carries data");

  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_mode |=>
    in_stall || (out_valid && out_status == pgs_pkg::ST_EMPTY))
    else $error("step request did not hold off the input");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pairwise_gravity_step pgs_checker u_pgs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_mode        (in_mode),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_body_index (out_body_index),
  .out_pos_x      (out_pos_x),
  .out_vel_y      (out_vel_y),
  .out_last       (out_last)
);
